// ===== rtl/crcpf_pkg.sv =====
// Package for the CRC-16 command packet framer.
// Holds packet layout constants, the CRC byte step and the microcode control word.
// No dependencies.
`timescale 1ns / 1ps

package crcpf_pkg;

	localparam logic [7:0]  SYNC0_BYTE = 8'hFF;
	localparam logic [7:0]  SYNC1_BYTE = 8'hFE;
	localparam logic [7:0]  LEN_BASE   = 8'h0C;
	localparam logic [15:0] CRC_INIT   = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'h1021;

	// Byte offsets within the packet
	localparam int OFS_SYNC0   = 0;
	localparam int OFS_SYNC1   = 1;
	localparam int OFS_CRC0    = 2;
	localparam int OFS_CRC1    = 3;
	localparam int OFS_LEN     = 4;
	localparam int OFS_CMD     = 14;
	localparam int OFS_DATA    = 18;
	localparam int MAX_LANES   = 8;

	// Input item layout on s_tdata
	localparam int CMD_LSB   = 0;
	localparam int DATA_LSB  = 16;
	localparam int CNT_LSB   = 80;
	localparam int HF_BIT    = 84;
	localparam int IN_TDATA_W = 88;

	typedef logic [1:0] upc_t;

	localparam upc_t UPC_WAIT = 2'd0;
	localparam upc_t UPC_CRC  = 2'd1;
	localparam upc_t UPC_REW  = 2'd2;
	localparam upc_t UPC_EMIT = 2'd3;

	typedef enum logic [1:0] {
		ADV_IN,
		ADV_ALWAYS,
		ADV_OUT
	} adv_t;

	typedef enum logic [1:0] {
		OFS_HOLD,
		OFS_LOAD_CRC,
		OFS_INC,
		OFS_CLEAR
	} ofs_op_t;

	typedef enum logic [1:0] {
		COND_NONE,
		COND_CRC_END,
		COND_OFS_LAST
	} cond_t;

	typedef struct packed {
		logic    in_ready;
		logic    crc_en;
		logic    out_valid;
		adv_t    adv;
		ofs_op_t ofs_op;
		cond_t   cond;
		upc_t    target;
	} uword_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic in_valid;
		logic out_ready;
		logic crc_end;
		logic ofs_last;
	} seq_flags_t;

	// Control from the sequencer to the datapath
	typedef struct packed {
		logic    in_ready;
		logic    crc_en;
		logic    out_valid;
		logic    fire;
		ofs_op_t ofs_op;
	} seq_ctrl_t;

	function automatic uword_t ucode(input upc_t pc);
		uword_t w;
		case (pc)
			UPC_WAIT: w = '{1'b1, 1'b0, 1'b0, ADV_IN, OFS_LOAD_CRC, COND_NONE, UPC_CRC};
			UPC_CRC:  w = '{1'b0, 1'b1, 1'b0, ADV_ALWAYS, OFS_INC, COND_CRC_END, UPC_REW};
			UPC_REW:  w = '{1'b0, 1'b0, 1'b0, ADV_ALWAYS, OFS_CLEAR, COND_NONE, UPC_EMIT};
			UPC_EMIT: w = '{1'b0, 1'b0, 1'b1, ADV_OUT, OFS_INC, COND_OFS_LAST, UPC_WAIT};
			default:  w = '{1'b0, 1'b0, 1'b0, ADV_ALWAYS, OFS_HOLD, COND_NONE, UPC_WAIT};
		endcase
		return w;
	endfunction

	// One byte of CRC-16, MSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/crc16_command_packet_framer_top.sv =====
// Sequence: after an item is accepted, a CRC pass runs over offsets 4 to 17 + count (one byte a cycle),
// a rewind step returns the offset to zero and the emit steps send the packet, holding while m_tready
// is low; the next request is accepted only after the last packet byte is taken, set by the microcode program.
// Reset: arst_n returns the step counter to the wait step; no item is pending after reset.
// Datapath: offset counter, CRC register and the latched request; crcpf_seq drives it.
`timescale 1ns / 1ps

module crc16_command_packet_framer_top #(
	parameter int PACKET_LEN = 64,
	parameter int MAX_DATA   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [15:0] command_id, [79:16] data_bytes, [83:80] data_count, [84] crc_high_first
	input  logic [87:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] packet_byte
	output logic [7:0]  m_tdata,
	output logic        m_tlast
);

	localparam int OFS_W = $clog2(PACKET_LEN);

	crcpf_pkg::seq_flags_t flags;
	crcpf_pkg::seq_ctrl_t  ctrl;

	logic [OFS_W-1:0] ofs_q;
	logic [15:0]      crc_q;
	logic [15:0]      cmd_q;
	logic [63:0]      data_q;
	logic [3:0]       cnt_q;
	logic             hf_q;

	logic [3:0]       cnt_in;
	logic [OFS_W-1:0] data_end;
	logic [2:0]       lane;
	logic [7:0]       cur_byte;
	logic             load;

	crcpf_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctrl   (ctrl)
	);

	assign load   = ctrl.fire & ctrl.in_ready;
	assign cnt_in = (s_tdata[crcpf_pkg::CNT_LSB +: 4] > 4'(MAX_DATA)) ? 4'(MAX_DATA)
		: s_tdata[crcpf_pkg::CNT_LSB +: 4];

	assign data_end = OFS_W'(crcpf_pkg::OFS_DATA) + OFS_W'(cnt_q);
	assign lane     = 3'(ofs_q - OFS_W'(crcpf_pkg::OFS_DATA));

	// Packet byte at the current offset
	always_comb begin
		cur_byte = 8'h00;
		if (ofs_q == OFS_W'(crcpf_pkg::OFS_SYNC0)) begin
			cur_byte = crcpf_pkg::SYNC0_BYTE;
		end else if (ofs_q == OFS_W'(crcpf_pkg::OFS_SYNC1)) begin
			cur_byte = crcpf_pkg::SYNC1_BYTE;
		end else if (ofs_q == OFS_W'(crcpf_pkg::OFS_CRC0)) begin
			cur_byte = hf_q ? crc_q[15:8] : crc_q[7:0];
		end else if (ofs_q == OFS_W'(crcpf_pkg::OFS_CRC1)) begin
			cur_byte = hf_q ? crc_q[7:0] : crc_q[15:8];
		end else if (ofs_q == OFS_W'(crcpf_pkg::OFS_LEN)) begin
			cur_byte = crcpf_pkg::LEN_BASE + 8'(cnt_q);
		end else if (ofs_q == OFS_W'(crcpf_pkg::OFS_CMD)) begin
			cur_byte = cmd_q[7:0];
		end else if (ofs_q == OFS_W'(crcpf_pkg::OFS_CMD + 1)) begin
			cur_byte = cmd_q[15:8];
		end else if (ofs_q >= OFS_W'(crcpf_pkg::OFS_DATA) && ofs_q < data_end) begin
			cur_byte = data_q[{lane, 3'b000} +: 8];
		end
	end

	always_comb begin
		flags.in_valid  = s_tvalid;
		flags.out_ready = m_tready;
		// last CRC byte sits at offset 17 + count
		flags.crc_end   = (ofs_q == data_end - OFS_W'(1));
		flags.ofs_last  = (ofs_q == OFS_W'(PACKET_LEN - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ofs_q <= '0;
		end else if (ctrl.fire) begin
			case (ctrl.ofs_op)
				crcpf_pkg::OFS_HOLD:     ofs_q <= ofs_q;
				crcpf_pkg::OFS_LOAD_CRC: ofs_q <= OFS_W'(crcpf_pkg::OFS_LEN);
				crcpf_pkg::OFS_INC:      ofs_q <= ofs_q + OFS_W'(1);
				crcpf_pkg::OFS_CLEAR:    ofs_q <= '0;
				default:                 ofs_q <= ofs_q;
			endcase
		end
	end

	// Request registers and CRC accumulator
	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q  <= s_tdata[crcpf_pkg::CMD_LSB +: 16];
			data_q <= s_tdata[crcpf_pkg::DATA_LSB +: 64];
			cnt_q  <= cnt_in;
			hf_q   <= s_tdata[crcpf_pkg::HF_BIT];
			crc_q  <= crcpf_pkg::CRC_INIT;
		end else if (ctrl.fire && ctrl.crc_en) begin
			crc_q <= crcpf_pkg::crc_byte(crc_q, cur_byte);
		end
	end

	assign s_tready = ctrl.in_ready;
	assign m_tvalid = ctrl.out_valid;
	assign m_tdata  = cur_byte;
	assign m_tlast  = ctrl.out_valid & flags.ofs_last;

endmodule

// ===== rtl/crcpf_seq.sv =====
// Microcode sequencer of the command packet framer: step counter and control ROM.
// Depends on crcpf_pkg.
`timescale 1ns / 1ps

module crcpf_seq (
	input  logic                  clk,
	input  logic                  arst_n,
	input  crcpf_pkg::seq_flags_t flags,
	output crcpf_pkg::seq_ctrl_t  ctrl
);

	crcpf_pkg::upc_t   upc_q;
	crcpf_pkg::upc_t   upc_d;
	crcpf_pkg::uword_t word;
	logic              fire;
	logic              take;

	always_comb begin
		word = crcpf_pkg::ucode(upc_q);
		case (word.adv)
			crcpf_pkg::ADV_IN:     fire = flags.in_valid;
			crcpf_pkg::ADV_ALWAYS: fire = 1'b1;
			crcpf_pkg::ADV_OUT:    fire = flags.out_ready;
			default:               fire = 1'b0;
		endcase
		case (word.cond)
			crcpf_pkg::COND_NONE:     take = 1'b1;
			crcpf_pkg::COND_CRC_END:  take = flags.crc_end;
			crcpf_pkg::COND_OFS_LAST: take = flags.ofs_last;
			default:                  take = 1'b0;
		endcase
		upc_d = (fire && take) ? word.target : upc_q;

		ctrl.in_ready  = word.in_ready;
		ctrl.crc_en    = word.crc_en;
		ctrl.out_valid = word.out_valid;
		ctrl.fire      = fire;
		ctrl.ofs_op    = word.ofs_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= crcpf_pkg::UPC_WAIT;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule
